// ===== hdl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the countdown timer table.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int SlotsDefault = 32;
  localparam int MaxResults   = 32;
  localparam int CmdW         = 2;
  localparam int KeyW         = 8;
  localparam int DurW         = 31;
  localparam int CbW          = 8;
  localparam int RemW         = 4;

  localparam logic [CmdW-1:0] CMD_TICK   = 2'd0;
  localparam logic [CmdW-1:0] CMD_NEW    = 2'd1;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd3;

  localparam logic [CmdW-1:0] KIND_EXPIRY = 2'd0;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] timer_key;
    logic [DurW-1:0] duration;
    logic [CbW-1:0]  callback_code;
  } item_t;

  typedef struct packed {
    logic [CmdW-1:0] kind;
    logic            ok;
    logic [KeyW-1:0] key_out;
    logic [CbW-1:0]  callback_out;
    logic [DurW-1:0] remaining;
    logic            last;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] timer_key;
    logic [DurW-1:0] loaded;
    logic [CbW-1:0]  callback_code;
  } job_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [DurW-1:0] count;
    logic [CbW-1:0]  callback;
  } slot_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

// ===== hdl/cdt_ram.sv =====
// ----------------------------------------------------------------------------
// cdt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cdt_front.sv =====
// ----------------------------------------------------------------------------
// cdt_front
// Accepts commands and rounds a new timer's duration down to a multiple of
// ten from a nibble-sum remainder, then pushes the job into the queue.
// ----------------------------------------------------------------------------
module cdt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cdt_pkg::item_t    in_item,
  input  logic              q_full,
  output logic              push,
  output cdt_pkg::job_t     push_job
);

  logic                          held;
  logic                          rem_ready;
  cdt_pkg::item_t                item;
  logic [cdt_pkg::RemW-1:0]      rem;
  logic [cdt_pkg::RemW-1:0]      rem_next;
  logic [31:0]                   dur_pad;
  logic [6:0]                    nib_sum;
  logic [4:0]                    fold;
  logic [2:0]                    rem5;
  logic                          ready_job;

  assign busy      = held;
  assign dur_pad   = {1'b0, item.duration};
  assign ready_job = held && rem_ready;
  assign push      = ready_job && !q_full;

  // 16 is 1 modulo 5, so the nibble sum keeps the value modulo 5; the low
  // bit then picks between that and that plus 5
  always_comb begin
    nib_sum = '0;
    for (int n = 0; n < 8; n++) begin
      nib_sum = nib_sum + 7'(dur_pad[4*n +: 4]);
    end
    fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
    if (fold >= 5'd20) begin
      rem5 = 3'(fold - 5'd20);
    end else if (fold >= 5'd15) begin
      rem5 = 3'(fold - 5'd15);
    end else if (fold >= 5'd10) begin
      rem5 = 3'(fold - 5'd10);
    end else if (fold >= 5'd5) begin
      rem5 = 3'(fold - 5'd5);
    end else begin
      rem5 = fold[2:0];
    end
    rem_next = (rem5[0] == dur_pad[0]) ? cdt_pkg::RemW'(rem5) :
               cdt_pkg::RemW'(rem5) + cdt_pkg::RemW'(5);
  end

  always_comb begin
    push_job.command       = item.command;
    push_job.timer_key     = item.timer_key;
    push_job.loaded        = item.duration - cdt_pkg::DurW'(rem);
    push_job.callback_code = item.callback_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      rem_ready <= 1'b0;
    end else if (start && !held) begin
      held      <= 1'b1;
      rem_ready <= 1'b0;
      item      <= in_item;
    end else if (held && !rem_ready) begin
      rem       <= rem_next;
      rem_ready <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

endmodule

// ===== hdl/cdt_queue.sv =====
// ----------------------------------------------------------------------------
// cdt_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module cdt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cdt_pkg::job_t    push_job,
  input  logic             pop,
  output cdt_pkg::job_t    pop_job,
  output cdt_pkg::qstat_t  stat
);

  cdt_pkg::job_t entry [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;

  assign pop_job    = entry[rptr];
  assign stat.valid = (fill != 2'd0);
  assign stat.full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        entry[wptr] <= push_job;
        wptr        <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/cdt_back.sv =====
// ----------------------------------------------------------------------------
// cdt_back
// Carries out jobs by walking the slot memory one entry a cycle: enabled
// ticks decrement and report expiries, other commands with a nonzero key search for the key.
// ----------------------------------------------------------------------------
module cdt_back #(
  parameter int SLOTS = cdt_pkg::SlotsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_enable,
  input  cdt_pkg::qstat_t  qstat,
  input  cdt_pkg::job_t    job_in,
  output logic             pop,
  output logic             result_valid,
  output cdt_pkg::result_t result
);

  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam int NW    = $clog2(cdt_pkg::MaxResults + 1);
  localparam int SlotW = $bits(cdt_pkg::slot_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t                  state;
  cdt_pkg::job_t           job;
  logic [CntW-1:0]         idx;
  logic                    rd_valid;
  logic [IdxW-1:0]         rd_idx;
  logic [SLOTS-1:0]        used;
  logic                    match_found;
  logic [IdxW-1:0]         match_idx;
  logic [cdt_pkg::DurW-1:0] match_count;
  logic                    free_found;
  logic [IdxW-1:0]         free_idx;
  logic                    hold_valid;
  logic [cdt_pkg::KeyW-1:0] hold_key;
  logic [cdt_pkg::CbW-1:0]  hold_cb;
  logic [NW-1:0]           n_emit;
  logic                    result_valid_next;
  cdt_pkg::result_t        result_next;

  logic                    ram_we;
  logic [IdxW-1:0]         ram_waddr;
  cdt_pkg::slot_t          ram_wslot;
  logic [SlotW-1:0]        ram_rdata;
  cdt_pkg::slot_t          rslot;
  logic                    is_tick;
  logic                    live;
  logic                    expire;

  cdt_ram #(.WIDTH(SlotW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (SlotW'(ram_wslot)),
    .raddr (idx[IdxW-1:0]),
    .rdata (ram_rdata)
  );

  assign rslot   = cdt_pkg::slot_t'(ram_rdata);
  assign is_tick = (job.command == cdt_pkg::CMD_TICK);
  assign live    = (state == S_SCAN) && rd_valid && used[rd_idx];
  assign expire  = live && is_tick && (rslot.count == cdt_pkg::DurW'(1)) &&
                   (rslot.callback != '0) && (n_emit < NW'(cdt_pkg::MaxResults));
  assign pop     = (state == S_IDLE) && qstat.valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wslot = rslot;
    if (live && is_tick && rslot.count != '0) begin
      ram_we          = 1'b1;
      ram_wslot.count = rslot.count - cdt_pkg::DurW'(1);
    end else if (state == S_DONE && job.command == cdt_pkg::CMD_NEW &&
                 (match_found || free_found)) begin
      ram_we             = 1'b1;
      ram_waddr          = match_found ? match_idx : free_idx;
      ram_wslot.key      = job.timer_key;
      ram_wslot.count    = job.loaded;
      ram_wslot.callback = job.callback_code;
    end
  end

  always_comb begin
    result_valid_next = 1'b0;
    result_next       = result;
    case (state)
      S_IDLE: begin
        if (qstat.valid && job_in.command != cdt_pkg::CMD_TICK &&
            job_in.timer_key == '0) begin
          result_valid_next        = 1'b1;
          result_next.kind         = job_in.command;
          result_next.ok           = 1'b0;
          result_next.key_out      = job_in.timer_key;
          result_next.callback_out = '0;
          result_next.remaining    = '0;
          result_next.last         = 1'b1;
        end
      end
      S_SCAN: begin
        if (expire) begin
          // hold each expiry until the next shows whether it is the last
          result_valid_next        = hold_valid;
          result_next.kind         = cdt_pkg::KIND_EXPIRY;
          result_next.ok           = 1'b1;
          result_next.key_out      = hold_key;
          result_next.callback_out = hold_cb;
          result_next.remaining    = '0;
          result_next.last         = 1'b0;
        end
      end
      S_DONE: begin
        result_next.kind         = job.command;
        result_next.ok           = match_found;
        result_next.key_out      = job.timer_key;
        result_next.callback_out = '0;
        result_next.remaining    = '0;
        result_next.last         = 1'b1;
        case (job.command)
          cdt_pkg::CMD_TICK: begin
            result_valid_next        = hold_valid;
            result_next.kind         = cdt_pkg::KIND_EXPIRY;
            result_next.ok           = 1'b1;
            result_next.key_out      = hold_key;
            result_next.callback_out = hold_cb;
          end
          cdt_pkg::CMD_NEW: begin
            result_valid_next = 1'b1;
            if (match_found || free_found) begin
              result_next.ok        = 1'b1;
              result_next.remaining = job.loaded;
            end
          end
          cdt_pkg::CMD_DELETE: begin
            result_valid_next = 1'b1;
          end
          default: begin
            result_valid_next = 1'b1;
            if (match_found) begin
              result_next.remaining = match_count;
            end
          end
        endcase
      end
      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      result_valid <= 1'b0;
      rd_valid     <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      case (state)
        S_IDLE: begin
          if (qstat.valid) begin
            job         <= job_in;
            idx         <= '0;
            rd_valid    <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            hold_valid  <= 1'b0;
            n_emit      <= '0;
            if (job_in.command == cdt_pkg::CMD_TICK) begin
              // drop ticks while disabled
              state <= tick_enable ? S_SCAN : S_IDLE;
            end else if (job_in.timer_key == '0) begin
              state <= S_WAIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx != CntW'(SLOTS)) begin
            rd_valid <= 1'b1;
            rd_idx   <= idx[IdxW-1:0];
            idx      <= idx + CntW'(1);
          end else begin
            rd_valid <= 1'b0;
          end
          if (rd_valid) begin
            if (!used[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (live && !is_tick && !match_found && rslot.key == job.timer_key) begin
              match_found <= 1'b1;
              match_idx   <= rd_idx;
              match_count <= rslot.count;
            end
          end
          if (expire) begin
            hold_valid <= 1'b1;
            hold_key   <= rslot.key;
            hold_cb    <= rslot.callback;
            n_emit     <= n_emit + NW'(1);
          end
          if (idx == CntW'(SLOTS) && !rd_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          case (job.command)
            cdt_pkg::CMD_NEW: begin
              if (match_found || free_found) begin
                used[match_found ? match_idx : free_idx] <= 1'b1;
              end
            end
            cdt_pkg::CMD_DELETE: begin
              if (match_found) begin
                used[match_idx] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state <= S_WAIT;
        end
        S_WAIT: begin
          // let the last beat leave before the next job
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/countdown_timer_table.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_table
// Table of SLOTS down-counting timers with new, delete, read and tick.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The front holds a
// command while it registers the remainder of a new timer's duration by ten,
// then hands the rounded job to a two-entry queue, and stays busy longer
// while the queue is full. The back walks the slot memory one entry a cycle
// for every command with a nonzero key and every enabled tick, and takes the
// next job from the queue only once it is idle again, so that walk sets the
// sustained rate; a null key and a disabled tick skip the walk. Each result
// beat appears on result for exactly one cycle with result_valid high and
// cannot be held off; a tick gives one beat per expiring timer with a
// callback, up to 32, the final one marked by last, and may give none.
// ----------------------------------------------------------------------------
module countdown_timer_table #(
  parameter int SLOTS = cdt_pkg::SlotsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cdt_pkg::item_t   in_item,
  input  logic             cfg_we,
  input  logic             cfg_data,
  output logic             result_valid,
  output cdt_pkg::result_t result
);

  logic            tick_enable;
  logic            push;
  logic            pop;
  cdt_pkg::job_t   push_job;
  cdt_pkg::job_t   pop_job;
  cdt_pkg::qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_enable <= 1'b0;
    end else if (cfg_we) begin
      tick_enable <= cfg_data;
    end
  end

  cdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .q_full   (qstat.full),
    .push     (push),
    .push_job (push_job)
  );

  cdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (qstat)
  );

  cdt_back #(.SLOTS(SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .tick_enable  (tick_enable),
    .qstat        (qstat),
    .job_in       (pop_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != cdt_pkg::KIND_EXPIRY |-> result.last)
    else $error("reply beat without last");

  a_reply_no_cb: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != cdt_pkg::KIND_EXPIRY |-> result.callback_out == '0)
    else $error("reply beat carries a callback");

  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == cdt_pkg::KIND_EXPIRY |->
      result.ok && result.remaining == '0 && result.callback_out != '0)
    else $error("malformed expiry beat");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

endmodule
